/* design/scog_pkg.sv */
// ----------------------------------------------------------------------------
// scog_pkg
// Shared types and constants for the scrolling occupancy grid.
// ----------------------------------------------------------------------------
package scog_pkg;

  localparam int GRID_SIZE_DEF = 64;
  localparam int SIDE_W        = 9;
  localparam int CRD_W         = 10;
  localparam int CELL_W        = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 8;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_SHIFT = 2'd2,
    CMD_MARK  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_SIZE = 2'd0,
    CFG_HIT_HALF  = 2'd1,
    CFG_EMPTY     = 2'd2,
    CFG_OBSTACLE  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    WK_NONE  = 2'd0,
    WK_CLR   = 2'd1,
    WK_SHIFT = 2'd2,
    WK_MARK  = 2'd3
  } wk_mode_t;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_CLEAR = 2'd1,
    WR_SHIFT = 2'd2,
    WR_MARK  = 2'd3
  } wr_sel_t;

  typedef struct packed {
    logic     accept;
    wk_mode_t wk_mode;
    logic     wk_step;
    wr_sel_t  wr_sel;
    logic     sh_read;
    logic     out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic wk_last;
    logic wk_empty;
    logic out_free;
  } ctl_sts_t;

endpackage

/* design/scrolling_occupancy_grid_core.sv */
// Read/write: each request is accepted, then its result register is loaded once the output is free.
// Shift: one read and one write per cell for active side n.
// Mark: one write per cell of the clipped box.
// Reset: synchronous; a clearing pass writes every cell of the GRID_SIZE by GRID_SIZE
// store to zero, with input stalled, config writes accepted throughout.
// ----------------------------------------------------------------------------
// scrolling_occupancy_grid_core
// Top level: scrolling occupancy grid with sequencer and datapath.
// ----------------------------------------------------------------------------
module scrolling_occupancy_grid_core #(
  parameter int GRID_SIZE = scog_pkg::GRID_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_cmd,
  input  logic signed [scog_pkg::CRD_W-1:0] in_coord_x,
  input  logic signed [scog_pkg::CRD_W-1:0] in_coord_y,
  input  logic signed [scog_pkg::CRD_W-1:0] in_shift_x,
  input  logic signed [scog_pkg::CRD_W-1:0] in_shift_y,
  input  logic [scog_pkg::CELL_W-1:0]       in_cell_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [scog_pkg::CELL_W-1:0]       out_read_value,
  output logic                              out_coord_error,
  input  logic                              cfg_we,
  input  logic [scog_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scog_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import scog_pkg::*;

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  scog_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .ctl      (ctl),
    .sts      (sts)
  );

  scog_datapath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_shift_x      (in_shift_x),
    .in_shift_y      (in_shift_y),
    .in_cell_value   (in_cell_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_coord_error (out_coord_error),
    .ctl             (ctl),
    .sts             (sts)
  );

  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in flight");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_coord_error) |-> (out_read_value == '0))
    else $error("nonzero read value with coordinate error");

endmodule

/* design/scog_ram.sv */
// ----------------------------------------------------------------------------
// scog_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module scog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/scog_datapath.sv */
// ----------------------------------------------------------------------------
// scog_datapath
// Config registers, cell store, 2D address walker and result register.
// ----------------------------------------------------------------------------
module scog_datapath #(
  parameter int GRID_SIZE = scog_pkg::GRID_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [1:0]                        in_cmd,
  input  logic signed [scog_pkg::CRD_W-1:0] in_coord_x,
  input  logic signed [scog_pkg::CRD_W-1:0] in_coord_y,
  input  logic signed [scog_pkg::CRD_W-1:0] in_shift_x,
  input  logic signed [scog_pkg::CRD_W-1:0] in_shift_y,
  input  logic [scog_pkg::CELL_W-1:0]       in_cell_value,
  input  logic                              cfg_we,
  input  logic [scog_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scog_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [scog_pkg::CELL_W-1:0]       out_read_value,
  output logic                              out_coord_error,
  input  scog_pkg::ctl_cmd_t                ctl,
  output scog_pkg::ctl_sts_t                sts
);
  import scog_pkg::*;

  localparam int AW = $clog2(GRID_SIZE);
  localparam int MW = 2 * AW;

  typedef struct packed {
    logic          emp;
    logic [AW-1:0] f;
    logic [AW-1:0] l;
  } span_t;

  function automatic span_t clip_span(input logic signed [CRD_W-1:0] c,
                                      input logic [6:0] h,
                                      input logic [SIDE_W-1:0] n);
    logic signed [11:0] lo;
    logic signed [11:0] hi;
    logic signed [11:0] nn;
    span_t s;
    nn = $signed({3'b000, n});
    lo = $signed({{2{c[CRD_W-1]}}, c}) - $signed({5'b00000, h});
    hi = $signed({{2{c[CRD_W-1]}}, c}) + $signed({5'b00000, h});
    if (lo < 12'sd0) begin
      lo = 12'sd0;
    end
    if (hi > nn) begin
      hi = nn;
    end
    s.emp = (lo >= hi);
    s.f   = lo[AW-1:0];
    hi    = hi - 12'sd1;
    s.l   = hi[AW-1:0];
    return s;
  endfunction

  logic [6:0]        gsz_r, half_r;
  logic [CELL_W-1:0] empty_r, obst_r;

  cmd_t              cmd_r;
  logic signed [CRD_W-1:0] x_r, y_r, dx_r, dy_r;
  logic              err_r;

  logic [AW-1:0] i_r, j_r, il_r, jf_r, jl_r;
  logic          idn_r, jdn_r, wk_empty_r;

  logic              out_valid_r;
  logic [CELL_W-1:0] out_val_r;
  logic              out_err_r;

  logic [SIDE_W-1:0] n, nm1;
  logic              x_rng, y_rng, in_rng;
  logic signed [11:0] si, sj, nn;
  logic              src_ok;
  span_t             sx, sy;
  logic              dx_pos, dy_pos;

  logic              ram_we, ram_re;
  logic [MW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  assign n   = ({2'b00, gsz_r} > SIDE_W'(GRID_SIZE)) ? SIDE_W'(GRID_SIZE) : {2'b00, gsz_r};
  assign nm1 = n - SIDE_W'(1);
  assign nn  = $signed({3'b000, n});

  assign x_rng  = !in_coord_x[CRD_W-1] && ($unsigned(in_coord_x) < {1'b0, n});
  assign y_rng  = !in_coord_y[CRD_W-1] && ($unsigned(in_coord_y) < {1'b0, n});
  assign in_rng = x_rng && y_rng;

  assign si = $signed({{(12-AW){1'b0}}, i_r}) - $signed({{2{dx_r[CRD_W-1]}}, dx_r});
  assign sj = $signed({{(12-AW){1'b0}}, j_r}) - $signed({{2{dy_r[CRD_W-1]}}, dy_r});
  assign src_ok = !si[11] && (si < nn) && !sj[11] && (sj < nn);

  assign sx = clip_span(x_r, half_r, n);
  assign sy = clip_span(y_r, half_r, n);
  assign dx_pos = !dx_r[CRD_W-1] && (dx_r != '0);
  assign dy_pos = !dy_r[CRD_W-1] && (dy_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gsz_r   <= 7'd64;
      half_r  <= 7'd6;
      empty_r <= 8'd0;
      obst_r  <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRID_SIZE: gsz_r   <= cfg_wdata[6:0];
        CFG_HIT_HALF:  half_r  <= cfg_wdata[6:0];
        CFG_EMPTY:     empty_r <= cfg_wdata;
        CFG_OBSTACLE:  obst_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r <= cmd_t'(in_cmd);
      x_r   <= in_coord_x;
      y_r   <= in_coord_y;
      dx_r  <= in_shift_x;
      dy_r  <= in_shift_y;
      err_r <= ((cmd_t'(in_cmd) == CMD_WRITE) || (cmd_t'(in_cmd) == CMD_READ)) && !in_rng;
    end
  end

  // address walker
  always_ff @(posedge clk) begin
    case (ctl.wk_mode)
      WK_CLR: begin
        il_r <= AW'(GRID_SIZE - 1); idn_r <= 1'b0;
        jf_r <= '0; jl_r <= AW'(GRID_SIZE - 1); jdn_r <= 1'b0;
        i_r  <= '0; j_r  <= '0;
        wk_empty_r <= 1'b0;
      end
      WK_SHIFT: begin
        il_r  <= dx_pos ? '0 : nm1[AW-1:0];
        idn_r <= dx_pos;
        i_r   <= dx_pos ? nm1[AW-1:0] : '0;
        jf_r  <= dy_pos ? nm1[AW-1:0] : '0;
        jl_r  <= dy_pos ? '0 : nm1[AW-1:0];
        jdn_r <= dy_pos;
        j_r   <= dy_pos ? nm1[AW-1:0] : '0;
        wk_empty_r <= (n == '0);
      end
      WK_MARK: begin
        il_r <= sx.l; idn_r <= 1'b0; i_r <= sx.f;
        jf_r <= sy.f; jl_r <= sy.l; jdn_r <= 1'b0; j_r <= sy.f;
        wk_empty_r <= sx.emp || sy.emp;
      end
      default: begin
        if (ctl.wk_step) begin
          if (j_r == jl_r) begin
            j_r <= jf_r;
            i_r <= idn_r ? i_r - AW'(1) : i_r + AW'(1);
          end else begin
            j_r <= jdn_r ? j_r - AW'(1) : j_r + AW'(1);
          end
        end
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {i_r, j_r};
    ram_wdata = obst_r;
    case (ctl.wr_sel)
      WR_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      WR_SHIFT: begin
        ram_we    = 1'b1;
        ram_wdata = src_ok ? ram_rdata : empty_r;
      end
      WR_MARK: begin
        ram_we    = 1'b1;
      end
      default: begin
        if (ctl.accept && (cmd_t'(in_cmd) == CMD_WRITE) && in_rng) begin
          ram_we    = 1'b1;
          ram_waddr = {in_coord_x[AW-1:0], in_coord_y[AW-1:0]};
          ram_wdata = in_cell_value;
        end
      end
    endcase
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = {si[AW-1:0], sj[AW-1:0]};
    if (ctl.sh_read) begin
      ram_re = 1'b1;
    end else if (ctl.accept && (cmd_t'(in_cmd) == CMD_READ) && in_rng) begin
      ram_re    = 1'b1;
      ram_raddr = {in_coord_x[AW-1:0], in_coord_y[AW-1:0]};
    end
  end

  scog_ram #(
    .WIDTH (CELL_W),
    .DEPTH (1 << MW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_val_r <= ((cmd_r == CMD_READ) && !err_r) ? ram_rdata : '0;
      out_err_r <= err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_val_r;
  assign out_coord_error = out_err_r;

  assign sts.wk_last  = (i_r == il_r) && (j_r == jl_r);
  assign sts.wk_empty = wk_empty_r;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

/* design/scog_ctrl.sv */
// ----------------------------------------------------------------------------
// scog_ctrl
// Command sequencer: clear pass, request accept, shift and mark walks.
// ----------------------------------------------------------------------------
module scog_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_cmd,
  output logic               in_stall,
  output scog_pkg::ctl_cmd_t ctl,
  input  scog_pkg::ctl_sts_t sts
);
  import scog_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_CLR, S_IDLE, S_SH_LD, S_SH_RD, S_SH_WR, S_MK_LD, S_MK, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_INIT: begin
        ctl.wk_mode = WK_CLR;
        state_nxt   = S_CLR;
      end
      S_CLR: begin
        ctl.wr_sel  = WR_CLEAR;
        ctl.wk_step = 1'b1;
        if (sts.wk_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          case (cmd_t'(in_cmd))
            CMD_SHIFT: state_nxt = S_SH_LD;
            CMD_MARK:  state_nxt = S_MK_LD;
            default:   state_nxt = S_EMIT;
          endcase
        end
      end
      S_SH_LD: begin
        ctl.wk_mode = WK_SHIFT;
        state_nxt   = S_SH_RD;
      end
      S_SH_RD: begin
        if (sts.wk_empty) begin
          state_nxt = S_EMIT;
        end else begin
          ctl.sh_read = 1'b1;
          state_nxt   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ctl.wr_sel  = WR_SHIFT;
        ctl.wk_step = 1'b1;
        state_nxt   = sts.wk_last ? S_EMIT : S_SH_RD;
      end
      S_MK_LD: begin
        ctl.wk_mode = WK_MARK;
        state_nxt   = S_MK;
      end
      S_MK: begin
        if (sts.wk_empty) begin
          state_nxt = S_EMIT;
        end else begin
          ctl.wr_sel  = WR_MARK;
          ctl.wk_step = 1'b1;
          if (sts.wk_last) state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule
